### rtl/priority_interrupt_controller_assert.svh
// Assertion macros for the interrupt controller.
// Each macro takes a label, a condition and a consequence, sampled on clk
// and disabled while rst is high.
`ifndef PRIORITY_INTERRUPT_CONTROLLER_ASSERT_SVH
`define PRIORITY_INTERRUPT_CONTROLLER_ASSERT_SVH
`ifndef SYNTH
// consequence holds in the same cycle
`define PIC_ASSERT_NOW(lbl, cond, conseq) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error("assertion failed");
// consequence holds in the next cycle
`define PIC_ASSERT_NEXT(lbl, cond, conseq) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("assertion failed");
`else
`define PIC_ASSERT_NOW(lbl, cond, conseq)
`define PIC_ASSERT_NEXT(lbl, cond, conseq)
`endif
`endif

### rtl/pic_pkg.sv
package pic_pkg;

  localparam int unsigned REG_BYTES  = 1024;
  localparam int unsigned NUM_INPUTS = 16;
  localparam int unsigned ADDR_W     = 10;

  typedef logic [7:0]                  byte_t;
  typedef logic [ADDR_W-1:0]           addr_t;
  typedef logic [12:0]                 offset_t;
  typedef logic [NUM_INPUTS-1:0]       pend_t;
  typedef logic [NUM_INPUTS-1:0][7:0]  prio_arr_t;

  // bus command codes
  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_LINE  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // register map
  localparam offset_t STATUS_REG = 13'h200;
  localparam offset_t PEND_HIGH  = 13'h202;
  localparam offset_t PEND_LOW   = 13'h203;
  localparam offset_t ACK_REG    = 13'h207;
  localparam offset_t WINDOW_END = 13'h400;
  localparam int unsigned ACK_INPUT = 10;

  // register file access
  typedef struct packed {
    logic  we;
    logic  re;
    addr_t addr;
    byte_t wdata;
  } mem_req_t;

endpackage

### rtl/pic_req_if.sv
interface pic_req_if;
  logic             valid;
  logic             ready;
  pic_pkg::cmd_t    cmd;
  logic [12:0]      offset;
  logic [7:0]       write_data;
  logic [3:0]       line_number;
  logic             line_level;

  modport source (output valid, cmd, offset, write_data, line_number, line_level,
                  input ready);
  modport sink   (input valid, cmd, offset, write_data, line_number, line_level,
                  output ready);
endinterface

### rtl/pic_rsp_if.sv
interface pic_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [7:0] ipl_level;
  logic       irq_taken;

  modport source (output valid, read_data, ipl_level, irq_taken, input ready);
  modport sink   (input valid, read_data, ipl_level, irq_taken, output ready);
endinterface

### rtl/pic_regmem.sv
// 1024 x 8 register file, one write and one registered read port.
// After reset a sweep writes zero to every byte, one per cycle.
module pic_regmem (
  input  logic              clk,
  input  logic              rst,
  input  pic_pkg::mem_req_t req,
  output pic_pkg::byte_t    rdata,
  output logic              busy
);

  pic_pkg::byte_t mem [pic_pkg::REG_BYTES];
  pic_pkg::addr_t clr_addr;
  logic           clearing;

  // clearing sweep control
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == '1) clearing <= 1'b0;
    end
  end

  // write port: sweep has priority, no beats are taken meanwhile
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (req.re) rdata <= mem[req.addr];
  end

  assign busy = clearing;

endmodule

### rtl/pic_level.sv
// Largest priority among pending inputs, as a four-level compare tree.
module pic_level (
  input  pic_pkg::prio_arr_t prio,
  input  pic_pkg::pend_t     pend,
  output pic_pkg::byte_t     level
);

  pic_pkg::byte_t l0 [16];
  pic_pkg::byte_t l1 [8];
  pic_pkg::byte_t l2 [4];
  pic_pkg::byte_t l3 [2];

  always_comb begin
    // mask out inputs that are not pending
    for (int i = 0; i < 16; i++) l0[i] = pend[i] ? prio[i] : '0;
    for (int i = 0; i < 8; i++) l1[i] = (l0[2*i] > l0[2*i+1]) ? l0[2*i] : l0[2*i+1];
    for (int i = 0; i < 4; i++) l2[i] = (l1[2*i] > l1[2*i+1]) ? l1[2*i] : l1[2*i+1];
    for (int i = 0; i < 2; i++) l3[i] = (l2[2*i] > l2[2*i+1]) ? l2[2*i] : l2[2*i+1];
    level = (l3[0] > l3[1]) ? l3[0] : l3[1];
  end

endmodule

### rtl/priority_interrupt_controller.sv
// Sixteen-input priority interrupt controller with a 1024-byte register file.
// One request beat (read, write or line change) is taken per cycle unless the
// reset sweep runs or the output stalls; its response beat is registered in
// stage 1 (the register file read) and then in the output register. Sustained
// rate is one beat per cycle; the register file's single read port is the
// limit. After reset the register file is swept to zero, during which no
// request is taken. Priorities, pending bits and the status byte are kept in
// flops next to the register file so the level (the largest pending priority)
// is ready every cycle; status bit 7 always reads as that level being nonzero.
`include "priority_interrupt_controller_assert.svh"

module priority_interrupt_controller (
  input  logic      clk,
  input  logic      rst,
  pic_req_if.sink   req,
  pic_rsp_if.source rsp
);

  logic                accept;
  logic                s1_adv;
  logic                busy;
  pic_pkg::mem_req_t   mreq;
  pic_pkg::byte_t      mem_q;
  pic_pkg::byte_t      level;

  logic                is_rd;
  logic                is_wr;
  logic                is_line;
  logic                in_window;
  logic                is_ack;
  logic                is_store;

  // shadowed registers
  pic_pkg::prio_arr_t  prio;
  pic_pkg::prio_arr_t  prio_next;
  pic_pkg::pend_t      pend;
  pic_pkg::pend_t      pend_next;
  logic [6:0]          status_lo;
  logic [6:0]          status_lo_next;

  // read capture for the second stage
  logic                s1_valid;
  logic                s1_zero;
  logic                s1_from_mem;
  logic                s1_is_status;
  pic_pkg::byte_t      s1_shadow;
  logic                sh_hit;
  logic                sh_status;
  pic_pkg::byte_t      sh_byte;

  assign s1_adv    = !rsp.valid || rsp.ready;
  assign req.ready = !busy && (!s1_valid || s1_adv);
  assign accept    = req.valid && req.ready;

  // command decode
  always_comb begin
    is_rd   = 1'b0;
    is_wr   = 1'b0;
    is_line = 1'b0;
    unique case (req.cmd)
      pic_pkg::CMD_READ:  is_rd   = 1'b1;
      pic_pkg::CMD_WRITE: is_wr   = 1'b1;
      pic_pkg::CMD_LINE:  is_line = 1'b1;
      default: ;
    endcase
  end

  assign in_window = req.offset < pic_pkg::WINDOW_END;
  assign is_ack    = is_wr && (req.offset == pic_pkg::ACK_REG);
  assign is_store  = is_wr && in_window && !is_ack;

  // shadow register update
  always_comb begin
    prio_next      = prio;
    pend_next      = pend;
    status_lo_next = status_lo;
    if (accept) begin
      if (is_ack) pend_next[pic_pkg::ACK_INPUT] = 1'b0;
      if (is_store) begin
        if (req.offset[12:4] == '0) prio_next[req.offset[3:0]] = req.write_data;
        if (req.offset == pic_pkg::STATUS_REG) status_lo_next = req.write_data[6:0];
        if (req.offset == pic_pkg::PEND_HIGH)  pend_next[15:8] = req.write_data;
        if (req.offset == pic_pkg::PEND_LOW)   pend_next[7:0]  = req.write_data;
      end
      if (is_line) pend_next[req.line_number] = req.line_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prio      <= '0;
      pend      <= '0;
      status_lo <= '0;
    end else begin
      prio      <= prio_next;
      pend      <= pend_next;
      status_lo <= status_lo_next;
    end
  end

  // shadow read mux
  always_comb begin
    sh_hit    = 1'b1;
    sh_status = 1'b0;
    sh_byte   = '0;
    if (req.offset[12:4] == '0) begin
      sh_byte = prio[req.offset[3:0]];
    end else if (req.offset == pic_pkg::STATUS_REG) begin
      sh_byte   = {1'b0, status_lo};
      sh_status = 1'b1;
    end else if (req.offset == pic_pkg::PEND_HIGH) begin
      sh_byte = pend[15:8];
    end else if (req.offset == pic_pkg::PEND_LOW) begin
      sh_byte = pend[7:0];
    end else begin
      sh_hit = 1'b0;
    end
  end

  // register file access
  always_comb begin
    mreq.we    = accept && is_store;
    mreq.re    = accept && is_rd && in_window && !sh_hit;
    mreq.addr  = req.offset[pic_pkg::ADDR_W-1:0];
    mreq.wdata = req.write_data;
  end

  pic_regmem u_regmem (
    .clk   (clk),
    .rst   (rst),
    .req   (mreq),
    .rdata (mem_q),
    .busy  (busy)
  );

  pic_level u_level (
    .prio  (prio),
    .pend  (pend),
    .level (level)
  );

  // stage 1 valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_zero      <= !(is_rd && in_window);
      s1_from_mem  <= !sh_hit;
      s1_is_status <= sh_status;
      s1_shadow    <= sh_byte;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (s1_adv) begin
      rsp.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      if (s1_zero) begin
        rsp.read_data <= '0;
      end else if (s1_from_mem) begin
        rsp.read_data <= mem_q;
      end else begin
        rsp.read_data <= s1_shadow | {s1_is_status && (level != '0), 7'b0};
      end
      rsp.ipl_level <= level;
      rsp.irq_taken <= level != '0;
    end
  end

  // checks
  `PIC_ASSERT_NOW(a_no_beat_in_sweep, busy, !req.ready)
  `PIC_ASSERT_NOW(a_hold_on_stall, s1_valid && !s1_adv, !req.ready)
  `PIC_ASSERT_NOW(a_irq_matches_level, rsp.valid, rsp.irq_taken == (rsp.ipl_level != '0))
  `PIC_ASSERT_NEXT(a_line_sets_pend, accept && is_line,
    pend[$past(req.line_number)] == $past(req.line_level))

endmodule
